### hw/rtl/bfsa_pkg.sv
// Shared types, codes and microcode table of the best-fit slot allocator.
package bfsa_pkg;

    // Item kinds carried in the input tuser bit.
    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    // Register index taken from paddr[2].
    localparam logic REG_SLOTS_IN_USE = 1'b0;

    localparam logic [4:0] SLOTS_IN_USE_RESET = 5'd16;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [2:0] {
        ST_FETCH,
        ST_LOAD,
        ST_SETUP,
        ST_SCAN,
        ST_FINISH
    } step_t;

    typedef enum logic [2:0] {
        OP_FETCH,
        OP_LOAD,
        OP_SETUP,
        OP_SCAN,
        OP_FINISH
    } op_t;

    // Jump conditions of the sequencer.
    typedef enum logic [2:0] {
        CND_ACCEPT,
        CND_ALWAYS,
        CND_EMPTY,
        CND_MORE,
        CND_OUT_FREE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctl_t;

    // Control store: one word per step.
    function automatic ctl_t ucode(step_t s);
        ctl_t w;
        case (s)
            ST_FETCH:  w = '{op: OP_FETCH,  cond: CND_ACCEPT,   target: ST_SETUP};
            ST_LOAD:   w = '{op: OP_LOAD,   cond: CND_ALWAYS,   target: ST_FINISH};
            ST_SETUP:  w = '{op: OP_SETUP,  cond: CND_EMPTY,    target: ST_FINISH};
            ST_SCAN:   w = '{op: OP_SCAN,   cond: CND_MORE,     target: ST_SCAN};
            ST_FINISH: w = '{op: OP_FINISH, cond: CND_OUT_FREE, target: ST_FETCH};
            default:   w = '{op: OP_FETCH,  cond: CND_ALWAYS,   target: ST_FETCH};
        endcase
        return w;
    endfunction

endpackage

### hw/rtl/bfsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bfsa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/best_fit_slot_allocator.sv
// Top level: microcoded best-fit slot allocator with stream ports and APB register.
//
//  channel   dir  handshake            payload
//  s_axis    in   tvalid/tready        tuser: func; tdata: slot_index, amount
//  m_axis    out  tvalid/tready        tuser: granted; tdata: chosen_slot, chosen_size
//  apb       in   psel/penable/pready  reg 0 at 0x0: slots_in_use
//
//  A request steps from accept to the next accept through fetch, setup, one scan step
//  per slot searched (min(slots_in_use, NUM_SLOTS) of them) and finish. The scan reads one slot
//  size a cycle from the size RAM's single read port. A load steps through fetch, load, finish.
//  Reset frees all slots and sets slots_in_use to 16; slot sizes are not cleared.
//  A result held in the output register stalls only the finish step of the next item.
module best_fit_slot_allocator #(
    parameter int NUM_SLOTS = 16,
    parameter int SIZE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [3:0] slot_index, [19:4] amount, [23:20] zero
    input  logic [0:0]  s_axis_tuser,   // [0] func
    // master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [3:0] chosen_slot, [19:4] chosen_size, [23:20] zero
    output logic [0:0]  m_axis_tuser,   // [0] granted
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int LIM_W = CNT_W > 5 ? CNT_W : 5;
    localparam int CMP_W = CNT_W > 4 ? CNT_W : 4;
    localparam int CW    = SIZE_BITS > 16 ? SIZE_BITS : 16;

    bfsa_pkg::step_t step_reg, step_next;
    bfsa_pkg::ctl_t  ctl;

    logic                 func_reg, func_next;
    logic [3:0]           idx_reg, idx_next;
    logic [15:0]          amount_reg, amount_next;
    logic [IDX_W-1:0]     cnt_reg, cnt_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     best_reg, best_next;
    logic [SIZE_BITS-1:0] best_size_reg, best_size_next;
    logic [NUM_SLOTS-1:0] taken_reg, taken_next;
    logic [4:0]           slots_in_use_reg, slots_in_use_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 m_granted_reg, m_granted_next;
    logic [3:0]           m_slot_reg, m_slot_next;
    logic [15:0]          m_size_reg, m_size_next;

    logic                 in_acc;
    logic                 out_free;
    logic                 cfg_wr;
    logic [LIM_W-1:0]     lim_wide;
    logic [CNT_W-1:0]     lim;
    logic                 scan_more;
    logic                 load_ok;
    logic                 fits;
    logic                 smaller;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [SIZE_BITS-1:0] ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [SIZE_BITS-1:0] ram_rdata;

    bfsa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (NUM_SLOTS)
    ) u_sizes (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ctl           = bfsa_pkg::ucode(step_reg);
    assign s_axis_tready = (ctl.op == bfsa_pkg::OP_FETCH);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_granted_reg;
    assign m_axis_tdata  = {4'b0, m_size_reg, m_slot_reg};

    // APB register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == bfsa_pkg::REG_SLOTS_IN_USE);
    assign prdata = (paddr[2] == bfsa_pkg::REG_SLOTS_IN_USE) ? 32'(slots_in_use_reg) : 32'b0;
    assign slots_in_use_next = cfg_wr ? pwdata[4:0] : slots_in_use_reg;

    // Saturate the search limit at the table depth.
    assign lim_wide  = (LIM_W'(slots_in_use_reg) > LIM_W'(NUM_SLOTS))
                       ? LIM_W'(NUM_SLOTS) : LIM_W'(slots_in_use_reg);
    assign lim       = CNT_W'(lim_wide);
    assign scan_more = (CNT_W'(cnt_reg) + CNT_W'(1)) != lim;
    assign load_ok   = CMP_W'(idx_reg) < CMP_W'(NUM_SLOTS);

    // Read data belongs to cnt_reg during the scan step.
    assign fits    = !taken_reg[cnt_reg] && (CW'(ram_rdata) >= CW'(amount_reg));
    assign smaller = !found_reg || (ram_rdata < best_size_reg);

    // Sequencer: next step
    always_comb
    begin
        step_next = step_reg;
        case (ctl.cond)
            bfsa_pkg::CND_ACCEPT:
            begin
                if (in_acc)
                begin
                    step_next = (s_axis_tuser[0] == bfsa_pkg::FUNC_REQUEST)
                                ? ctl.target : bfsa_pkg::step_t'(step_reg + 3'd1);
                end
            end
            bfsa_pkg::CND_ALWAYS:
            begin
                step_next = ctl.target;
            end
            bfsa_pkg::CND_EMPTY:
            begin
                step_next = (lim == '0) ? ctl.target : bfsa_pkg::step_t'(step_reg + 3'd1);
            end
            bfsa_pkg::CND_MORE:
            begin
                step_next = scan_more ? ctl.target : bfsa_pkg::step_t'(step_reg + 3'd1);
            end
            bfsa_pkg::CND_OUT_FREE:
            begin
                if (out_free)
                begin
                    step_next = ctl.target;
                end
            end
            default:
            begin
                step_next = bfsa_pkg::ST_FETCH;
            end
        endcase
    end

    // Datapath driven by the control word
    always_comb
    begin
        func_next      = func_reg;
        idx_next       = idx_reg;
        amount_next    = amount_reg;
        cnt_next       = cnt_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        best_size_next = best_size_reg;
        taken_next     = taken_reg;
        m_valid_next   = m_valid_reg;
        m_granted_next = m_granted_reg;
        m_slot_next    = m_slot_reg;
        m_size_next    = m_size_reg;
        ram_we         = 1'b0;
        ram_waddr      = IDX_W'(idx_reg);
        ram_wdata      = SIZE_BITS'(amount_reg);
        ram_raddr      = cnt_reg + IDX_W'(1);

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (ctl.op)
            bfsa_pkg::OP_FETCH:
            begin
                if (in_acc)
                begin
                    func_next   = s_axis_tuser[0];
                    idx_next    = s_axis_tdata[3:0];
                    amount_next = s_axis_tdata[19:4];
                end
            end
            bfsa_pkg::OP_LOAD:
            begin
                found_next = 1'b0;
                if (load_ok)
                begin
                    ram_we                      = 1'b1;
                    taken_next[IDX_W'(idx_reg)] = 1'b0;
                end
            end
            bfsa_pkg::OP_SETUP:
            begin
                cnt_next   = '0;
                found_next = 1'b0;
                ram_raddr  = '0;
            end
            bfsa_pkg::OP_SCAN:
            begin
                cnt_next = cnt_reg + IDX_W'(1);
                // Strict less-than keeps the lowest index on ties.
                if (fits && smaller)
                begin
                    found_next     = 1'b1;
                    best_next      = cnt_reg;
                    best_size_next = ram_rdata;
                end
            end
            bfsa_pkg::OP_FINISH:
            begin
                if (out_free)
                begin
                    m_valid_next   = 1'b1;
                    m_granted_next = found_reg;
                    m_slot_next    = found_reg ? 4'(best_reg) : 4'b0;
                    m_size_next    = found_reg ? 16'(CW'(best_size_reg)) : 16'b0;
                    if (found_reg)
                    begin
                        taken_next[best_reg] = 1'b1;
                    end
                end
            end
            default:
            begin
                found_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= bfsa_pkg::ST_FETCH;
            taken_reg        <= '0;
            slots_in_use_reg <= bfsa_pkg::SLOTS_IN_USE_RESET;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            step_reg         <= step_next;
            taken_reg        <= taken_next;
            slots_in_use_reg <= slots_in_use_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        idx_reg       <= idx_next;
        amount_reg    <= amount_next;
        cnt_reg       <= cnt_next;
        found_reg     <= found_next;
        best_reg      <= best_next;
        best_size_reg <= best_size_next;
        m_granted_reg <= m_granted_next;
        m_slot_reg    <= m_slot_next;
        m_size_reg    <= m_size_next;
    end

    // A refused request or a load carries an all-zero payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("refusal with nonzero payload");

    // The scan counter never leaves the searched range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == bfsa_pkg::ST_SCAN) |-> (CNT_W'(cnt_reg) < lim))
        else $error("scan past limit");

    // A slot picked for a request is large enough for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == bfsa_pkg::ST_FINISH && found_reg && func_reg == bfsa_pkg::FUNC_REQUEST)
        |-> (CW'(best_size_reg) >= CW'(amount_reg)))
        else $error("chosen slot too small");

endmodule

### bench/bfsa_grant_checker.sv
// Scoreboard for the best-fit slot allocator: predicts each grant and checks the output stream.
module bfsa_grant_checker #(
    parameter int NUM_SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [3:0] slot_index, [19:4] amount, [23:20] zero
    input  logic [0:0]  s_axis_tuser,   // [0] func
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // [3:0] chosen_slot, [19:4] chosen_size, [23:20] zero
    input  logic [0:0]  m_axis_tuser,   // [0] granted
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fails,
    output int          pending,
    output int          n_loads,
    output int          n_granted,
    output int          n_refused
);

    typedef struct packed {
        logic        granted;
        logic [3:0]  slot;
        logic [15:0] size;
    } grant_t;

    logic [15:0] size_tab [NUM_SLOTS];
    logic        taken    [NUM_SLOTS];
    logic [4:0]  in_use;
    grant_t      grant_q [$];

    initial
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            size_tab[i] = '0;
        end
    end

    // Apply one input word to the slot table and return the grant it yields.
    function automatic grant_t best_fit_pick(logic func, logic [3:0] idx, logic [15:0] amt);
        grant_t g;
        int     lim;
        bit     found;
        g = '0;
        if (func == bfsa_pkg::FUNC_LOAD)
        begin
            if (idx < NUM_SLOTS)
            begin
                size_tab[idx] = amt;
                taken[idx]    = 1'b0;
            end
            return g;
        end
        lim   = (in_use > NUM_SLOTS) ? NUM_SLOTS : in_use;
        found = 0;
        for (int j = 0; j < lim; j++)
        begin
            // strict less-than keeps the lowest index on equal sizes
            if (!taken[j] && size_tab[j] >= amt && (!found || size_tab[j] < g.size))
            begin
                found  = 1;
                g.slot = j[3:0];
                g.size = size_tab[j];
            end
        end
        if (found)
        begin
            g.granted     = 1'b1;
            taken[g.slot] = 1'b1;
        end
        return g;
    endfunction

    task automatic report_mismatch(string what, int want_v, int got_v);
        fails++;
        $display("mismatch on %s: expected %0d, got %0d at %0t", what, want_v, got_v,
                 $realtime);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grant_t want;
        grant_t got;
        grant_t g;
        if (!rst_n)
        begin
            in_use = bfsa_pkg::SLOTS_IN_USE_RESET;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                taken[i] = 1'b0;
            end
            grant_q.delete();
            fails     = 0;
            n_loads   = 0;
            n_granted = 0;
            n_refused = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready
                && paddr[2] == bfsa_pkg::REG_SLOTS_IN_USE)
            begin
                in_use = pwdata[4:0];
            end
            // check the output side first so a word accepted this edge cannot match itself
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = '{granted: m_axis_tuser[0], slot: m_axis_tdata[3:0],
                        size: m_axis_tdata[19:4]};
                if (grant_q.size() == 0)
                begin
                    report_mismatch("unexpected result word", 0, 1);
                end
                else
                begin
                    want = grant_q.pop_front();
                    if (got.granted !== want.granted)
                        report_mismatch("granted", want.granted, got.granted);
                    if (got.slot !== want.slot)
                        report_mismatch("chosen_slot", want.slot, got.slot);
                    if (got.size !== want.size)
                        report_mismatch("chosen_size", want.size, got.size);
                    if (m_axis_tdata[23:20] !== 4'd0)
                        report_mismatch("tdata pad", 0, m_axis_tdata[23:20]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                g = best_fit_pick(s_axis_tuser[0], s_axis_tdata[3:0], s_axis_tdata[19:4]);
                grant_q.push_back(g);
                if (s_axis_tuser[0] == bfsa_pkg::FUNC_LOAD)
                    n_loads++;
                else if (g.granted)
                    n_granted++;
                else
                    n_refused++;
            end
        end
        pending = grant_q.size();
    end

endmodule

### bench/tb_best_fit_slot_allocator.sv
// Testbench top for the best-fit slot allocator: stimulus, flow control and verdict.
module tb_best_fit_slot_allocator;

    localparam int LIMIT_CYCLES = 400000;
    localparam int LONG_HOLD    = 400;
    localparam int NUM_PHASES   = 8;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic [0:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    int fails, pending, n_loads, n_granted, n_refused;
    int cur_in_use = int'(bfsa_pkg::SLOTS_IN_USE_RESET);
    int cycles     = 0;
    bit quiet      = 0;
    bit holding    = 0;
    int stall_left = 0;
    event long_hold_ev;

    always #4 clk = ~clk;

    best_fit_slot_allocator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    bfsa_grant_checker u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fails         (fails),
        .pending       (pending),
        .n_loads       (n_loads),
        .n_granted     (n_granted),
        .n_refused     (n_refused)
    );

    // Receiver: short random stalls, plus one long hold-off driven below.
    always @(negedge clk)
    begin
        if (holding)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Hold the output off long enough for the block to back up into its input.
    initial
    begin
        @(long_hold_ev);
        @(posedge clk);
        holding = 1;
        repeat (LONG_HOLD) @(posedge clk);
        holding = 0;
    end

    initial
    begin
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL best_fit_slot_allocator");
        $finish;
    end

    // Call at a falling edge; returns at the falling edge after the word is taken.
    task automatic push_word(logic func, logic [3:0] idx, logic [15:0] amt);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {4'd0, amt, idx};
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Drain every outstanding result, then let the longest scan finish.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (24) @(negedge clk);
    endtask

    task automatic write_slots_in_use(logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {bfsa_pkg::REG_SLOTS_IN_USE, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_in_use = value[4:0];
    endtask

    function automatic logic [15:0] pick_amount();
        logic [15:0] palette [8] = '{16'd0, 16'd1, 16'd7, 16'd64, 16'd100, 16'd1000,
                                     16'h8000, 16'hFFFE};
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(0, 65535));
            default: return 16'(palette[3'($urandom_range(0, 7))] + $urandom_range(0, 1));
        endcase
    endfunction

    task automatic push_random();
        int          lim;
        logic [3:0]  idx;
        lim = (cur_in_use > 16) ? 16 : cur_in_use;
        if ($urandom_range(0, 99) < 55)
        begin
            push_word(bfsa_pkg::FUNC_REQUEST, 4'($urandom_range(0, 15)), pick_amount());
        end
        else
        begin
            // mostly load slots that the search can see, so grants keep coming
            if (lim > 0 && $urandom_range(0, 9) < 7)
                idx = 4'($urandom_range(0, lim - 1));
            else
                idx = 4'($urandom_range(0, 15));
            push_word(bfsa_pkg::FUNC_LOAD, idx, pick_amount());
        end
    endtask

    initial
    begin
        logic [15:0] first_sizes [16] = '{16'd0, 16'hFFFF, 16'd300, 16'd7, 16'd2000, 16'd100,
                                          16'd40000, 16'd512, 16'd9, 16'd100, 16'hFFFE,
                                          16'd1, 16'd777, 16'd4096, 16'd123, 16'd30000};
        int phase_cfg [NUM_PHASES] = '{1, 16, 3, 31, 0, 9, 16, 12};
        int phase_len [NUM_PHASES] = '{150, 260, 180, 200, 30, 220, 230, 230};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Fill every slot first, so no search ever reads a size that was never loaded.
        for (int i = 0; i < 16; i++)
        begin
            push_word(bfsa_pkg::FUNC_LOAD, i[3:0], first_sizes[i]);
        end
        push_word(bfsa_pkg::FUNC_REQUEST, 4'd0, 16'd0);       // zero-size slot is still granted
        push_word(bfsa_pkg::FUNC_REQUEST, 4'd15, 16'hFFFF);   // only the full-size slot fits
        push_word(bfsa_pkg::FUNC_REQUEST, 4'd0, 16'd100);     // tie: lowest index wins
        push_word(bfsa_pkg::FUNC_REQUEST, 4'd0, 16'd100);     // next one of the tie
        push_word(bfsa_pkg::FUNC_REQUEST, 4'd0, 16'hFFFF);    // nothing left that fits

        wait_idle();
        write_slots_in_use(32'd0);
        push_word(bfsa_pkg::FUNC_REQUEST, 4'd0, 16'd0);       // empty search refuses everything
        wait_idle();
        write_slots_in_use(32'd31);                           // saturates to the table size
        push_word(bfsa_pkg::FUNC_LOAD, 4'd1, 16'hFFFF);
        push_word(bfsa_pkg::FUNC_REQUEST, 4'd0, 16'hFFFF);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            if (p == NUM_PHASES - 1)
            begin
                @(posedge clk);
                quiet = 1;
                @(negedge clk);
            end
            write_slots_in_use(phase_cfg[p]);
            for (int n = 0; n < phase_len[p]; n++)
            begin
                if (p == 1 && n == 40)
                    -> long_hold_ev;
                push_random();
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (30) @(posedge clk);

        $display("covered %0d loads and %0d requests (%0d granted, %0d refused)",
                 n_loads, n_granted + n_refused, n_granted, n_refused);
        $display("slot counts swept from 0 to 31, with one long output hold-off");
        if (fails == 0)
            $display("PASS best_fit_slot_allocator");
        else
            $display("FAIL best_fit_slot_allocator");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/bfsa_pkg.sv
hw/rtl/bfsa_ram.sv
hw/rtl/best_fit_slot_allocator.sv
bench/bfsa_grant_checker.sv
bench/tb_best_fit_slot_allocator.sv
